/* rtl/matrix3_inverse_core_defines.svh */
// Assertion macros for the 3x3 matrix inverse core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MATRIX3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3_INVERSE_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define MTX_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MTX_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define MTX_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define MTX_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

/* rtl/mtx3inv_pkg.sv */
// Shared types and constants for the 3x3 matrix inverse core.
// No dependencies.
package mtx3inv_pkg;

    localparam int MAT_W = 32;            // entry width
    localparam int THR_W = 16;            // threshold register width
    localparam int COF_W = 2 * MAT_W + 1; // exact cofactor
    localparam int DET_W = 3 * MAT_W + 3; // exact determinant
    localparam int QB    = MAT_W + 1;     // quotient bits developed

    typedef logic signed [MAT_W-1:0] entry_t;

    typedef struct packed {
        entry_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
    } mtx_in_t;

    typedef struct packed {
        entry_t b00, b01, b02, b10, b11, b12, b20, b21, b22;
        logic   singular;
        logic   saturated;
    } mtx_out_t;

    typedef struct packed {
        logic valid;
        logic singular;
    } mtx_ctl_t;

    // signed cofactor c[i] = a[P]*a[Q] - a[R]*a[S], sign of the adjugate folded in
    localparam int COF_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

/* rtl/mtx3inv_cof.sv */
// Cofactor stages: 18 entry products, then nine signed differences.
// Depends on mtx3inv_pkg.
module mtx3inv_cof
    import mtx3inv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid,
    input  entry_t                  a [9],
    output logic                    cof_valid,
    output logic signed [COF_W-1:0] cof [9],
    output entry_t                  row [3]
);

    logic signed [2*MAT_W-1:0] pa_reg [9];
    logic signed [2*MAT_W-1:0] pb_reg [9];
    entry_t                    row1_reg [3];
    logic                      v1_reg;
    logic signed [COF_W-1:0]   cof_reg [9];
    entry_t                    row2_reg [3];
    logic                      v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                pa_reg[i]  <= a[COF_P[i]] * a[COF_Q[i]];
                pb_reg[i]  <= a[COF_R[i]] * a[COF_S[i]];
                cof_reg[i] <= COF_W'(pa_reg[i]) - COF_W'(pb_reg[i]);
            end
            for (int k = 0; k < 3; k++)
            begin
                row1_reg[k] <= a[k];
                row2_reg[k] <= row1_reg[k];
            end
        end
    end

    assign cof_valid = v2_reg;
    assign cof       = cof_reg;
    assign row       = row2_reg;

endmodule

/* rtl/mtx3inv_det.sv */
// Determinant stages: split products, sum, then magnitudes and the singular test.
// Depends on mtx3inv_pkg.
module mtx3inv_det
    import mtx3inv_pkg::*;
#(
    parameter int F = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid,
    input  logic signed [COF_W-1:0] cof [9],
    input  entry_t                  row [3],
    input  logic [THR_W-1:0]        thr,
    output mtx_ctl_t                ctl,
    output logic [COF_W-1:0]        cmag [9],
    output logic                    cneg [9],
    output logic [DET_W-1:0]        dmag
);

    localparam int TW0 = (DET_W > THR_W + 2 * F) ? DET_W : THR_W + 2 * F;

    logic signed [2*MAT_W:0]   plo_reg [3];
    logic signed [2*MAT_W:0]   phi_reg [3];
    logic signed [COF_W-1:0]   c3_reg [9];
    logic                      v3_reg;
    logic signed [DET_W-1:0]   det_reg;
    logic signed [DET_W-1:0]   det_next;
    logic signed [COF_W-1:0]   c4_reg [9];
    logic                      v4_reg;
    logic [COF_W-1:0]          cmag_reg [9];
    logic                      cneg_reg [9];
    logic [DET_W-1:0]          dmag_reg;
    logic [DET_W-1:0]          dmag_next;
    mtx_ctl_t                  ctl_reg;
    logic                      sing_next;

    always_comb
    begin
        det_next = '0;
        for (int k = 0; k < 3; k++)
            det_next = det_next + (DET_W'(phi_reg[k]) <<< MAT_W) + DET_W'(plo_reg[k]);
    end

    always_comb
    begin
        dmag_next = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        sing_next = TW0'(dmag_next) <= (TW0'(thr) << (2 * F));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v3_reg           <= valid;
            v4_reg           <= v3_reg;
            ctl_reg.valid    <= v4_reg;
            ctl_reg.singular <= sing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                plo_reg[k] <= row[k] * $signed({1'b0, cof[3*k][MAT_W-1:0]});
                phi_reg[k] <= row[k] * $signed(cof[3*k][COF_W-1:MAT_W]);
            end
            for (int i = 0; i < 9; i++)
            begin
                c3_reg[i]   <= cof[i];
                c4_reg[i]   <= c3_reg[i];
                // quotient sign: cofactor sign against determinant sign
                cneg_reg[i] <= c4_reg[i][COF_W-1] ^ det_reg[DET_W-1];
                cmag_reg[i] <= c4_reg[i][COF_W-1] ? COF_W'(-c4_reg[i]) : COF_W'(c4_reg[i]);
            end
            det_reg  <= det_next;
            dmag_reg <= dmag_next;
        end
    end

    assign ctl  = ctl_reg;
    assign cmag = cmag_reg;
    assign cneg = cneg_reg;
    assign dmag = dmag_reg;

endmodule

/* rtl/mtx3inv_div.sv */
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient bit a stage.
// Depends on mtx3inv_pkg.
module mtx3inv_div
    import mtx3inv_pkg::*;
#(
    parameter int F = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  mtx_ctl_t         ctl_in,
    input  logic [COF_W-1:0] cmag [9],
    input  logic             cneg [9],
    input  logic [DET_W-1:0] dmag,
    output mtx_ctl_t         ctl_out,
    output logic [QB-1:0]    quo [9],
    output logic             ovf [9],
    output logic             neg [9]
);

    localparam int RW  = COF_W + 2 * F;
    localparam int XW0 = (RW > DET_W + QB) ? RW : DET_W + QB;
    localparam int XW  = XW0 + 1;

    logic [RW-1:0]    rem_reg [QB+1][9];
    logic [QB-1:0]    q_reg   [QB+1][9];
    logic             ovf_reg [QB+1][9];
    logic             neg_reg [QB+1][9];
    logic [DET_W-1:0] d_reg   [QB+1];
    mtx_ctl_t         ctl_reg [QB+1];

    // entry stage: scale numerator, flag quotients of more than QB bits
    logic [RW-1:0] num_next [9];
    logic          ovf_next [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            num_next[i] = RW'(cmag[i]) << (2 * F);
            ovf_next[i] = XW'(num_next[i]) >= (XW'(dmag) << QB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (en)
            ctl_reg[0] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                rem_reg[0][i] <= num_next[i];
                q_reg[0][i]   <= '0;
                ovf_reg[0][i] <= ovf_next[i];
                neg_reg[0][i] <= cneg[i];
            end
            d_reg[0] <= dmag;
        end
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_stage
        localparam int K = QB - s;

        logic [XW-1:0] trial_next [9];

        always_comb
        begin
            for (int i = 0; i < 9; i++)
                trial_next[i] = XW'(rem_reg[s-1][i]) - (XW'(d_reg[s-1]) << K);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[s] <= '0;
            else if (en)
                ctl_reg[s] <= ctl_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    rem_reg[s][i] <= trial_next[i][XW-1] ? rem_reg[s-1][i]
                                                         : trial_next[i][RW-1:0];
                    q_reg[s][i]   <= q_reg[s-1][i] | (QB'(!trial_next[i][XW-1]) << K);
                    ovf_reg[s][i] <= ovf_reg[s-1][i];
                    neg_reg[s][i] <= neg_reg[s-1][i];
                end
                d_reg[s] <= d_reg[s-1];
            end
        end
    end

    assign ctl_out = ctl_reg[QB];
    assign quo     = q_reg[QB];
    assign ovf     = ovf_reg[QB];
    assign neg     = neg_reg[QB];

endmodule

/* rtl/matrix3_inverse_core.sv */
// 3x3 matrix inverse core: adjugate over exact determinant, fully pipelined.
// Depends on mtx3inv_pkg, mtx3inv_cof, mtx3inv_det, mtx3inv_div and the defines header.
//
// Takes one signed fixed-point 3x3 matrix per word and returns its inverse.
// Throughput is one matrix per clock while the output is not stalled. The
// pipeline is 2 cofactor stages, 3 determinant stages, the divider's
// entry stage plus one stage per quotient bit (QB = entry width + 1), and
// the output register. The divider length sets the latency. When the output
// word is stalled the whole pipeline holds and in_stall rises, so nothing
// is dropped or repeated. A determinant whose magnitude is at or below
// singular_threshold (in units of 2^-FRAC_BITS) gives the identity and
// raises singular; otherwise each entry is truncated toward zero and
// clamped to the entry range, with saturated reporting any clamp.
// singular_threshold resets to 0 and should only be written while idle.
`include "matrix3_inverse_core_defines.svh"
module matrix3_inverse_core
    import mtx3inv_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  mtx_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output mtx_out_t         out_data,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_data
);

    localparam logic [QB-1:0] LIM = QB'(1) << (MAT_W - 1);
    localparam entry_t ONE  = entry_t'(MAT_W'(1) << FRAC_BITS);
    localparam entry_t EMAX = {1'b0, {(MAT_W-1){1'b1}}};
    localparam entry_t EMIN = {1'b1, {(MAT_W-1){1'b0}}};

    logic [THR_W-1:0]        thr_reg;
    logic                    en;
    entry_t                  a [9];
    logic                    cof_valid;
    logic signed [COF_W-1:0] cof [9];
    entry_t                  row [3];
    mtx_ctl_t                det_ctl;
    logic [COF_W-1:0]        cmag [9];
    logic                    cneg [9];
    logic [DET_W-1:0]        dmag;
    mtx_ctl_t                div_ctl;
    logic [QB-1:0]           quo [9];
    logic                    ovf [9];
    logic                    neg [9];
    entry_t                  b_next [9];
    logic                    sat_next;
    mtx_out_t                out_next;
    mtx_out_t                out_data_reg;
    logic                    out_valid_reg;

    // pipeline advances unless a finished word sits stalled at the output
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    assign a[0] = in_data.a00;
    assign a[1] = in_data.a01;
    assign a[2] = in_data.a02;
    assign a[3] = in_data.a10;
    assign a[4] = in_data.a11;
    assign a[5] = in_data.a12;
    assign a[6] = in_data.a20;
    assign a[7] = in_data.a21;
    assign a[8] = in_data.a22;

    mtx3inv_cof u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (in_valid),
        .a         (a),
        .cof_valid (cof_valid),
        .cof       (cof),
        .row       (row)
    );

    mtx3inv_det #(.F(FRAC_BITS)) u_det (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .valid (cof_valid),
        .cof   (cof),
        .row   (row),
        .thr   (thr_reg),
        .ctl   (det_ctl),
        .cmag  (cmag),
        .cneg  (cneg),
        .dmag  (dmag)
    );

    mtx3inv_div #(.F(FRAC_BITS)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (det_ctl),
        .cmag    (cmag),
        .cneg    (cneg),
        .dmag    (dmag),
        .ctl_out (div_ctl),
        .quo     (quo),
        .ovf     (ovf),
        .neg     (neg)
    );

    // sign, clamp, or identity for the singular case
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            if (div_ctl.singular)
                b_next[i] = (i % 4 == 0) ? ONE : '0;
            else if (!neg[i] && (ovf[i] || quo[i] >= LIM))
            begin
                b_next[i] = EMAX;
                sat_next  = 1'b1;
            end
            else if (neg[i] && (ovf[i] || quo[i] > LIM))
            begin
                b_next[i] = EMIN;
                sat_next  = 1'b1;
            end
            else
                b_next[i] = neg[i] ? entry_t'(-quo[i]) : entry_t'(quo[i]);
        end
        out_next.b00       = b_next[0];
        out_next.b01       = b_next[1];
        out_next.b02       = b_next[2];
        out_next.b10       = b_next[3];
        out_next.b11       = b_next[4];
        out_next.b12       = b_next[5];
        out_next.b20       = b_next[6];
        out_next.b21       = b_next[7];
        out_next.b22       = b_next[8];
        out_next.singular  = div_ctl.singular;
        out_next.saturated = sat_next && !div_ctl.singular;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MTX_ASSERT_IMP(a_sing_no_sat, clk, rst_n, out_valid && out_data.singular, !out_data.saturated, "singular word flagged saturated")
    `MTX_ASSERT_IMP(a_sing_ident, clk, rst_n, out_valid && out_data.singular, out_data.b00 == ONE && out_data.b01 == '0 && out_data.b22 == ONE, "singular word is not identity")
    `MTX_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without an output stall")
    `MTX_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled output word lost")

endmodule

/* verif/tb_matrix3_inverse_core.sv */
// Self-checking bench for matrix3_inverse_core: a directed table, then random matrices.
// Depends on mtx3inv_pkg and the matrix3_inverse_core RTL.
`timescale 1ns / 1ps
module tb_matrix3_inverse_core;
    import mtx3inv_pkg::*;

    localparam int FRAC      = 16;
    localparam int LAT_WAIT  = 60;        // whole pipeline is QB + 7 = 40 deep
    localparam int CYC_LIMIT = 400000;
    localparam int WIDE      = 160;       // enough for cofactor << 2*FRAC and det

    typedef entry_t mat9_t [9];
    typedef logic signed [WIDE-1:0] wide_t;

    // random matrix flavors
    typedef enum int {GEN_FULL, GEN_SMALL, GEN_NEAR_SING, GEN_TINY_DIAG} gen_kind_t;

    // one directed row; typed_exp marks a hand-written expectation
    typedef struct {
        mtx_in_t  m;
        bit       typed_exp;
        mtx_out_t exp;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    mtx_in_t          in_data;
    logic             out_valid;
    logic             out_stall;
    mtx_out_t         out_data;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_data;

    mtx_out_t         inverse_q [$];      // expected words, oldest first
    logic [THR_W-1:0] thr_shadow;         // bench copy of singular_threshold
    int               err_cnt;
    int               cyc_cnt;
    bit               calm;               // no idling on either side
    int               hold_cycles;        // long receiver hold-off request

    matrix3_inverse_core #(.FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYC_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic mat9_t in_to_arr(mtx_in_t m);
        mat9_t r;
        r = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
        return r;
    endfunction

    function automatic mtx_out_t arr_to_out(mat9_t b, logic sing, logic sat);
        mtx_out_t o;
        o.b00 = b[0]; o.b01 = b[1]; o.b02 = b[2];
        o.b10 = b[3]; o.b11 = b[4]; o.b12 = b[5];
        o.b20 = b[6]; o.b21 = b[7]; o.b22 = b[8];
        o.singular  = sing;
        o.saturated = sat;
        return o;
    endfunction

    function automatic mtx_in_t arr_to_in(mat9_t a);
        mtx_in_t m;
        m.a00 = a[0]; m.a01 = a[1]; m.a02 = a[2];
        m.a10 = a[3]; m.a11 = a[4]; m.a12 = a[5];
        m.a20 = a[6]; m.a21 = a[7]; m.a22 = a[8];
        return m;
    endfunction

    // Exact adjugate / determinant in wide signed arithmetic. Signed '/' truncates
    // toward zero, which is what the block does on |num| / |det| with sign fixup.
    function automatic mtx_out_t predict_inverse(mtx_in_t m, logic [THR_W-1:0] thr);
        mat9_t a;
        mat9_t b;
        wide_t w [9];
        wide_t adj [9];
        wide_t det;
        wide_t dmag;
        wide_t quo;
        wide_t hi;
        wide_t lo;
        logic  sat;
        a   = in_to_arr(m);
        sat = 1'b0;
        hi  = (wide_t'(1) <<< (MAT_W - 1)) - 1;
        lo  = -(wide_t'(1) <<< (MAT_W - 1));
        for (int i = 0; i < 9; i++)
            w[i] = wide_t'(a[i]);
        // cofactor table with the adjugate sign already folded in
        for (int i = 0; i < 9; i++)
            adj[i] = w[COF_P[i]] * w[COF_Q[i]] - w[COF_R[i]] * w[COF_S[i]];
        det  = w[0] * adj[0] + w[1] * adj[3] + w[2] * adj[6];
        dmag = (det < 0) ? -det : det;
        if (dmag <= (wide_t'(thr) <<< (2 * FRAC)))
        begin
            for (int i = 0; i < 9; i++)
                b[i] = (i % 4 == 0) ? entry_t'(1 << FRAC) : '0;
            return arr_to_out(b, 1'b1, 1'b0);
        end
        for (int i = 0; i < 9; i++)
        begin
            quo = (adj[i] <<< (2 * FRAC)) / det;
            if (quo > hi)
            begin
                quo = hi;
                sat = 1'b1;
            end
            else if (quo < lo)
            begin
                quo = lo;
                sat = 1'b1;
            end
            b[i] = entry_t'(quo);
        end
        return arr_to_out(b, 1'b0, sat);
    endfunction

    task automatic report_mismatch(string what, logic [MAT_W-1:0] got, logic [MAT_W-1:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cyc_cnt);
        err_cnt++;
    endtask

    // Output monitor. Sampled at the falling edge: everything seen here holds through
    // the next rising edge, so valid && !stall means the word is taken there.
    always @(negedge clk)
    begin
        mtx_out_t want;
        mat9_t    gb;
        mat9_t    wb;
        if (rst_n && out_valid && !out_stall)
        begin
            if (inverse_q.size() == 0)
                report_mismatch("unexpected word b00", out_data.b00, '0);
            else
            begin
                want = inverse_q.pop_front();
                gb = '{out_data.b00, out_data.b01, out_data.b02, out_data.b10, out_data.b11,
                       out_data.b12, out_data.b20, out_data.b21, out_data.b22};
                wb = '{want.b00, want.b01, want.b02, want.b10, want.b11,
                       want.b12, want.b20, want.b21, want.b22};
                for (int i = 0; i < 9; i++)
                    if (gb[i] !== wb[i])
                        report_mismatch($sformatf("b%0d%0d", i / 3, i % 3), gb[i], wb[i]);
                if (out_data.singular !== want.singular)
                    report_mismatch("singular", out_data.singular, want.singular);
                if (out_data.saturated !== want.saturated)
                    report_mismatch("saturated", out_data.saturated, want.saturated);
            end
        end
    end

    // Receiver: random stalls, none while calm, and a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 20);
    end

    // Offer one word and hold it until taken; queue the expectation on acceptance.
    task automatic send_word(mtx_in_t m, bit typed_exp, mtx_out_t exp);
        bit taken;
        in_data  <= m;
        in_valid <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        inverse_q.push_back(typed_exp ? exp : predict_inverse(m, thr_shadow));
        // sender gap: drop valid for a cycle now and then
        if (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Wait for all expected words, then let the pipe run dry before touching config.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        thr_shadow = v;
    endtask

    function automatic entry_t rnd_small();
        return entry_t'(int'($urandom_range(196608)) - 98304);   // about +/-1.5
    endfunction

    function automatic mtx_in_t gen_matrix(gen_kind_t kind);
        mat9_t a;
        case (kind)
            GEN_FULL:
                for (int i = 0; i < 9; i++)
                    a[i] = entry_t'($urandom);
            GEN_SMALL:
                for (int i = 0; i < 9; i++)
                    a[i] = rnd_small();
            GEN_NEAR_SING:
            begin
                // third row is a mix of the first two plus a little noise
                for (int i = 0; i < 6; i++)
                    a[i] = rnd_small();
                for (int i = 0; i < 3; i++)
                    a[6 + i] = a[i] + a[3 + i] + entry_t'(int'($urandom_range(64)) - 32);
            end
            default:
            begin
                // raw-unit diagonal: inverse overflows and clamps unless the threshold marks it singular
                a = '{default: '0};
                for (int i = 0; i < 9; i += 4)
                    a[i] = entry_t'(int'($urandom_range(6)) - 3);
                if (a[0] == 0) a[0] = 1;
                if (a[4] == 0) a[4] = -1;
                if (a[8] == 0) a[8] = 1;
            end
        endcase
        return arr_to_in(a);
    endfunction

    function automatic mtx_in_t diag(entry_t d0, entry_t d1, entry_t d2);
        mat9_t a;
        a = '{default: '0};
        a[0] = d0;
        a[4] = d1;
        a[8] = d2;
        return arr_to_in(a);
    endfunction

    localparam entry_t ONE  = entry_t'(1 << FRAC);
    localparam entry_t EMAX = entry_t'(32'h7fff_ffff);
    localparam entry_t EMIN = entry_t'(32'h8000_0000);

    initial
    begin
        stim_row_t rows [$];
        stim_row_t r;
        mtx_out_t  ident;
        mtx_out_t  none;
        mat9_t     a;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        err_cnt     = 0;
        cyc_cnt     = 0;
        calm        = 1'b0;
        hold_cycles = 0;
        thr_shadow  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        ident = arr_to_out('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1, 1'b0);
        none  = '0;

        // Directed table, threshold at its reset value of zero.
        // zero matrix: determinant zero, always singular
        rows.push_back('{diag(0, 0, 0), 1'b1, ident});
        // all-max and all-min: equal rows, determinant zero
        a = '{default: EMAX};
        rows.push_back('{arr_to_in(a), 1'b1, ident});
        a = '{default: EMIN};
        rows.push_back('{arr_to_in(a), 1'b1, ident});
        // identity maps to itself, not flagged singular
        r = '{diag(ONE, ONE, ONE), 1'b1, ident};
        r.exp.singular = 1'b0;
        rows.push_back(r);
        // 2*I gives 0.5 on the diagonal
        rows.push_back('{diag(2 * ONE, 2 * ONE, 2 * ONE), 1'b1,
                         arr_to_out('{32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h8000},
                                    1'b0, 1'b0)});
        // raw-unit diagonal: clamps to max
        rows.push_back('{diag(1, 1, 1), 1'b1,
                         arr_to_out('{EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX}, 1'b0, 1'b1)});
        // negative raw-unit diagonal: clamps to min
        rows.push_back('{diag(-1, -1, -1), 1'b1,
                         arr_to_out('{EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN}, 1'b0, 1'b1)});
        // predicted rows: extremes mixed with a nonzero determinant, permutation, signs
        rows.push_back('{diag(EMAX, EMIN, EMAX), 1'b0, none});
        rows.push_back('{diag(EMIN, EMIN, EMIN), 1'b0, none});
        rows.push_back('{diag(ONE, -ONE, ONE), 1'b0, none});
        rows.push_back('{arr_to_in('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}), 1'b0, none});
        rows.push_back('{arr_to_in('{EMAX, EMIN, 1, -1, EMAX, 0, ONE, 3, EMIN}), 1'b0, none});
        rows.push_back('{arr_to_in('{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE,
                                     5 * ONE, 6 * ONE, 0}), 1'b0, none});
        // determinant of exactly one raw unit cubed stays invertible at threshold 0
        rows.push_back('{diag(1, 1, -1), 1'b0, none});

        foreach (rows[i])
            send_word(rows[i].m, rows[i].typed_exp, rows[i].exp);
        drain_pipe();

        // Random phases across threshold settings, extremes included.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_threshold(16'hffff);
                1: write_threshold(16'h0000);
                2: write_threshold(THR_W'($urandom));
                3: write_threshold(16'h0001);
                default: write_threshold(16'h4000);
            endcase
            calm = (ph == 2);
            // long receiver hold-off while the sender keeps offering, fills the pipe
            if (ph == 1)
                hold_cycles = 300;
            for (int n = 0; n < 110; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2: send_word(gen_matrix(GEN_FULL), 1'b0, none);
                    3, 4, 5: send_word(gen_matrix(GEN_SMALL), 1'b0, none);
                    6, 7:    send_word(gen_matrix(GEN_NEAR_SING), 1'b0, none);
                    default: send_word(gen_matrix(GEN_TINY_DIAG), 1'b0, none);
                endcase
            end
            drain_pipe();
        end
        calm = 1'b0;

        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
